/* rtl/spa_pkg.sv */
// ----------------------------------------------------------------------------
// spa_pkg
// Types and constants shared by the source port pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package spa_pkg;

  localparam int ADDR_W       = 32;
  localparam int PORT_W       = 16;
  localparam int COUNT_W      = 13;
  localparam int ADDR_COUNT_W = 3;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 32;

  localparam logic [ADDR_COUNT_W-1:0] ADDR_COUNT_RESET = 3'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_BASE_ADDRESS  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ADDRESS_COUNT = 8'd1;

  localparam logic ACT_FETCH  = 1'b0;
  localparam logic ACT_RETURN = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic wr_en;
    logic wr_bit;
  } used_ctl_t;

endpackage

`default_nettype wire

/* rtl/spa_cfg_if.sv */
// ----------------------------------------------------------------------------
// spa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface spa_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [spa_pkg::CFG_INDEX_W-1:0]    index;
  logic [spa_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/spa_req_if.sv */
// ----------------------------------------------------------------------------
// spa_req_if
// Request channel: fetch a free pair or return a given pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface spa_req_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [spa_pkg::ADDR_W-1:0]    ret_address;
  logic [spa_pkg::PORT_W-1:0]    ret_port;

  modport source (output valid, action, ret_address, ret_port, input ready);
  modport sink   (input valid, action, ret_address, ret_port, output ready);
endinterface

`default_nettype wire

/* rtl/spa_rsp_if.sv */
// ----------------------------------------------------------------------------
// spa_rsp_if
// Response channel: status, fetched pair and pool counts.
// ----------------------------------------------------------------------------
`default_nettype none

interface spa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [spa_pkg::ADDR_W-1:0]    got_address;
  logic [spa_pkg::PORT_W-1:0]    got_port;
  logic [spa_pkg::COUNT_W-1:0]   free_count;
  logic [spa_pkg::COUNT_W-1:0]   used_count;

  modport source (output valid, status, got_address, got_port, free_count, used_count,
                  input ready);
  modport sink   (input valid, status, got_address, got_port, free_count, used_count,
                  output ready);
endinterface

`default_nettype wire

/* rtl/spa_used_mem.sv */
// ----------------------------------------------------------------------------
// spa_used_mem
// In-use bit per pool entry, single port write / single port read RAM,
// with a clearing sweep after reset or a clear command.
// ----------------------------------------------------------------------------
`default_nettype none

module spa_used_mem #(
  parameter int DEPTH = 4096,
  parameter int IDX_W = 12
) (
  input  wire                     clk,
  input  wire                     rst,
  input  spa_pkg::used_ctl_t      ctl,
  input  wire [IDX_W-1:0]         wr_addr,
  input  wire [IDX_W-1:0]         rd_addr,
  output logic                    rd_bit,
  output logic                    busy
);

  logic             mem [DEPTH];
  logic [IDX_W-1:0] clr_idx;
  logic [IDX_W-1:0] w_addr;
  logic             w_bit;
  logic             w_en;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      if (clr_idx == IDX_W'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_comb begin
    if (busy) begin
      w_en   = 1'b1;
      w_addr = clr_idx;
      w_bit  = 1'b0;
    end else begin
      w_en   = ctl.wr_en;
      w_addr = wr_addr;
      w_bit  = ctl.wr_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (w_en) begin
      mem[w_addr] <= w_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_bit <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/source_port_pool_allocator.sv */
// ----------------------------------------------------------------------------
// source_port_pool_allocator
// Pool of (source address, port) pairs kept on a free FIFO in RAM, with an
// in-use bit per pair. Fetch pops the oldest free pair; return range-checks
// a pair, maps it to its entry, checks its in-use bit and pushes it back.
//
//   channel  dir  handshake     payload
//   cfg      in   valid/ready   index, data (0 base_address, 1 address_count)
//   req      in   valid/ready   action, ret_address, ret_port
//   rsp      out  valid/ready   status, got_address, got_port, free/used count
//
// A request passes through three steps: accept and decode, RAM read, update and
// register the response; the next request is taken after that.
// The FIFO read and the in-use bit read-modify-write set these steps.
// After reset and after a write to register 0 or 1, a clearing pass runs over
// every entry of the in-use RAM; req is held off.
// A stalled rsp holds the block in its update step until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module source_port_pool_allocator #(
  parameter int MAX_ADDRESSES     = 4,
  parameter int FIRST_PORT        = 1024,
  parameter int PORTS_PER_ADDRESS = 1024
) (
  input  wire          clk,
  input  wire          rst,
  spa_cfg_if.sink      cfg,
  spa_req_if.sink      req,
  spa_rsp_if.source    rsp
);

  localparam int CAP = MAX_ADDRESSES * PORTS_PER_ADDRESS;
  localparam int EW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CW  = $clog2(CAP + 1);
  localparam int AW  = (MAX_ADDRESSES > 1) ? $clog2(MAX_ADDRESSES) : 1;
  localparam int PW  = (PORTS_PER_ADDRESS > 1) ? $clog2(PORTS_PER_ADDRESS) : 1;
  localparam int ACW = $clog2(MAX_ADDRESSES + 1);
  localparam int FW  = AW + PW;

  // configuration
  logic [spa_pkg::ADDR_W-1:0]       base_q;
  logic [spa_pkg::ADDR_COUNT_W-1:0] count_q;
  logic                             cfg_hit;

  assign cfg.ready = 1'b1;
  assign cfg_hit   = cfg.valid && cfg.ready &&
                     (cfg.index == spa_pkg::CFG_BASE_ADDRESS ||
                      cfg.index == spa_pkg::CFG_ADDRESS_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      base_q  <= '0;
      count_q <= spa_pkg::ADDR_COUNT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == spa_pkg::CFG_BASE_ADDRESS) begin
        base_q <= cfg.data;
      end else if (cfg.index == spa_pkg::CFG_ADDRESS_COUNT) begin
        count_q <= cfg.data[spa_pkg::ADDR_COUNT_W-1:0];
      end
    end
  end

  logic [ACW-1:0] act_addr;
  logic [CW-1:0]  n_entries;

  assign act_addr  = (32'(count_q) > 32'(MAX_ADDRESSES)) ? ACW'(MAX_ADDRESSES)
                                                          : ACW'(count_q);
  assign n_entries = CW'(32'(act_addr) * 32'(PORTS_PER_ADDRESS));

  // control state
  spa_pkg::state_t state, state_next;
  logic [EW-1:0]   head;
  logic [AW-1:0]   head_ai;
  logic [PW-1:0]   head_pi;
  logic [EW-1:0]   tail;
  logic [CW-1:0]   low_mark;
  logic [CW-1:0]   free_total;

  // request capture
  logic            act_q;
  logic            range_ok_q;
  logic [AW-1:0]   ai_q;
  logic [PW-1:0]   pi_q;
  logic [EW-1:0]   uidx_q;

  logic [31:0]     ra;
  logic [15:0]     rp;
  logic            range_ok;

  assign ra       = req.ret_address - base_q;
  assign rp       = req.ret_port - 16'(FIRST_PORT);
  assign range_ok = (ra < 32'(act_addr)) && (32'(rp) < 32'(PORTS_PER_ADDRESS));

  // memories
  logic [FW-1:0]   fifo_mem [CAP];
  logic [FW-1:0]   fifo_rd;
  logic            used_rd;
  logic            clr_busy;
  spa_pkg::used_ctl_t used_ctl;
  logic [EW-1:0]   used_wr_addr;

  // handshake and sequencing
  logic req_fire;
  logic rd_en;
  logic exec_fire;

  always_comb begin
    state_next = state;
    unique case (state)
      spa_pkg::S_IDLE: if (req_fire) state_next = spa_pkg::S_READ;
      spa_pkg::S_READ: state_next = spa_pkg::S_EXEC;
      spa_pkg::S_EXEC: if (exec_fire) state_next = spa_pkg::S_IDLE;
      default:         state_next = spa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = (state == spa_pkg::S_IDLE) && !clr_busy;
    rd_en     = (state == spa_pkg::S_READ);
    exec_fire = (state == spa_pkg::S_EXEC) && (!rsp.valid || rsp.ready);
  end

  assign req_fire = req.valid && req.ready;

  // update step
  logic                        stored;
  logic [AW-1:0]               f_ai;
  logic [PW-1:0]               f_pi;
  logic [EW-1:0]               f_idx;
  spa_pkg::status_t            st;
  logic [spa_pkg::ADDR_W-1:0]  g_addr;
  logic [spa_pkg::PORT_W-1:0]  g_port;
  logic [CW-1:0]               free_next;
  logic                        pop;
  logic                        push;

  assign stored = (CW'(head) < low_mark) || (CW'(head) >= n_entries);
  assign f_ai   = stored ? fifo_rd[FW-1:PW] : head_ai;
  assign f_pi   = stored ? fifo_rd[PW-1:0]  : head_pi;
  assign f_idx  = EW'(32'(f_ai) * 32'(PORTS_PER_ADDRESS) + 32'(f_pi));

  always_comb begin
    st        = spa_pkg::ST_OK;
    g_addr    = '0;
    g_port    = '0;
    free_next = free_total;
    pop       = 1'b0;
    push      = 1'b0;
    if (act_q == spa_pkg::ACT_FETCH) begin
      if (free_total == '0) begin
        st = spa_pkg::ST_EMPTY;
      end else begin
        pop       = 1'b1;
        free_next = free_total - 1'b1;
        g_addr    = base_q + 32'(f_ai);
        g_port    = 16'(FIRST_PORT) + 16'(f_pi);
      end
    end else begin
      if (!range_ok_q) begin
        st = spa_pkg::ST_RANGE;
      end else if (!used_rd) begin
        st = spa_pkg::ST_NOT_USED;
      end else begin
        push      = 1'b1;
        free_next = free_total + 1'b1;
      end
    end
  end

  always_comb begin
    used_ctl.clear  = cfg_hit;
    used_ctl.rd_en  = rd_en;
    used_ctl.wr_en  = exec_fire && (pop || push);
    used_ctl.wr_bit = pop;
    used_wr_addr    = pop ? f_idx : uidx_q;
  end

  spa_used_mem #(
    .DEPTH (CAP),
    .IDX_W (EW)
  ) u_used (
    .clk     (clk),
    .rst     (rst),
    .ctl     (used_ctl),
    .wr_addr (used_wr_addr),
    .rd_addr (uidx_q),
    .rd_bit  (used_rd),
    .busy    (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (exec_fire && push) begin
      fifo_mem[tail] <= {ai_q, pi_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fifo_rd <= fifo_mem[head];
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      act_q      <= req.action;
      range_ok_q <= range_ok;
      ai_q       <= ra[AW-1:0];
      pi_q       <= rp[PW-1:0];
      uidx_q     <= EW'(32'(ra[AW-1:0]) * 32'(PORTS_PER_ADDRESS) + 32'(rp[PW-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= spa_pkg::S_IDLE;
      head       <= '0;
      head_ai    <= '0;
      head_pi    <= '0;
      tail       <= '0;
      low_mark   <= '0;
      free_total <= '0;
    end else begin
      state <= state_next;
      if (clr_busy) begin
        // refill: entries 0 .. n-1 in order, read back through the split counters
        head       <= '0;
        head_ai    <= '0;
        head_pi    <= '0;
        tail       <= (n_entries >= CW'(CAP)) ? '0 : EW'(n_entries);
        low_mark   <= '0;
        free_total <= n_entries;
      end else if (exec_fire) begin
        free_total <= free_next;
        if (pop) begin
          if (head == EW'(CAP - 1)) begin
            head    <= '0;
            head_ai <= '0;
            head_pi <= '0;
          end else if (head_pi == PW'(PORTS_PER_ADDRESS - 1)) begin
            head    <= head + 1'b1;
            head_ai <= head_ai + 1'b1;
            head_pi <= '0;
          end else begin
            head    <= head + 1'b1;
            head_pi <= head_pi + 1'b1;
          end
        end
        if (push) begin
          tail <= (tail == EW'(CAP - 1)) ? '0 : tail + 1'b1;
          if (CW'(tail) == low_mark) begin
            low_mark <= low_mark + 1'b1;
          end
        end
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (exec_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      rsp.status      <= st;
      rsp.got_address <= g_addr;
      rsp.got_port    <= g_port;
      rsp.free_count  <= spa_pkg::COUNT_W'(free_next);
      rsp.used_count  <= spa_pkg::COUNT_W'(n_entries - free_next);
    end
  end

`ifndef ASSERT_OFF
  a_free_bounded: assert property (@(posedge clk) disable iff (rst)
    !clr_busy |-> free_total <= n_entries)
    else $error("free count exceeds pool size");

  a_read_then_exec: assert property (@(posedge clk) disable iff (rst)
    state == spa_pkg::S_READ |=> state == spa_pkg::S_EXEC)
    else $error("RAM read not followed by update step");

  a_exec_done: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> state == spa_pkg::S_IDLE && rsp.valid)
    else $error("update step did not present a response");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !req.ready && state != spa_pkg::S_EXEC)
    else $error("request taken during clearing pass");
`endif

endmodule

`default_nettype wire
